### hw/rtl/bedg_pkg.sv
`timescale 1ns / 1ps

package bedg_pkg;

    localparam int SMP_W      = 16;
    localparam int ENV_W      = 23;
    localparam int AMT_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int COEF_W     = 15;
    localparam int Q_SHIFT    = 5;
    localparam int MA_W       = 24;
    localparam int MB_W       = 29;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int AMTK_W     = 28;
    localparam int MIX_SHIFT  = 10;
    localparam int DET_SHIFT  = 15;
    localparam int DUCK_SHIFT = 35;
    localparam int STEP_W     = 5;

    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(20);
    localparam logic [ENV_W-1:0]  ENV_MAX    = '1;
    localparam logic [AMT_W-1:0]  UNITY      = 16'd32768;
    localparam logic [COEF_W-1:0] MIX_M_COEF = 15'd23593;
    localparam logic [COEF_W-1:0] MIX_D_COEF = 15'd9175;

    localparam logic [COEF_W-1:0] DET_KEEP [4] = '{15'd32276, 15'd31949, 15'd31293, 15'd30638};
    localparam logic [COEF_W-1:0] DET_TAKE [4] = '{15'd492, 15'd819, 15'd1475, 15'd2130};
    localparam logic [COEF_W-1:0] ENV_DECAY [4] = '{15'd32604, 15'd32637, 15'd32637, 15'd32670};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        A_MONO,
        A_DIFF,
        A_DET,
        A_DRIVE,
        A_ENV,
        A_AMT
    } t_a_sel;

    typedef enum logic [2:0] {
        B_MIX_M,
        B_MIX_D,
        B_KEEP,
        B_TAKE,
        B_DECAY,
        B_DUCK_K,
        B_AMTK
    } t_b_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        W_NONE,
        W_DRIVE1,
        W_DET,
        W_ENV,
        W_AMTK,
        W_GAIN
    } t_wr_sel;

    typedef struct packed {
        logic       load;
        logic       publish;
        t_acc_op    acc_op;
        t_a_sel     a_sel;
        logic [1:0] a_idx;
        t_b_sel     b_sel;
        logic [1:0] b_idx;
        t_wr_sel    wr_sel;
        logic [1:0] wr_idx;
    } t_dp_cmd;

    function automatic logic [COEF_W-1:0] duck_k(input logic [1:0] idx);
        logic [COEF_W-1:0] k;
        case (idx)
            2'd0:    k = 15'd5898;
            2'd1:    k = 15'd4915;
            2'd2:    k = 15'd3932;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [GAIN_W-1:0] duck_max(input logic [1:0] idx);
        logic [GAIN_W-1:0] m;
        case (idx)
            2'd0:    m = 16'd8192;
            2'd1:    m = 16'd6554;
            2'd2:    m = 16'd5898;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/bedg_ctrl.sv
`timescale 1ns / 1ps

module bedg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bedg_pkg::t_dp_cmd o_cmd
);
    import bedg_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;

    function automatic t_dp_cmd mac_cmd(
        input t_acc_op    op,
        input t_a_sel     a,
        input logic [1:0] ai,
        input t_b_sel     b,
        input logic [1:0] bi,
        input t_wr_sel    w,
        input logic [1:0] wi
    );
        t_dp_cmd c;
        c.load    = 1'b0;
        c.publish = 1'b0;
        c.acc_op  = op;
        c.a_sel   = a;
        c.a_idx   = ai;
        c.b_sel   = b;
        c.b_idx   = bi;
        c.wr_sel  = w;
        c.wr_idx  = wi;
        return c;
    endfunction

    function automatic t_dp_cmd idle_cmd();
        return mac_cmd(ACC_HOLD, A_MONO, 2'd0, B_MIX_M, 2'd0, W_NONE, 2'd0);
    endfunction

    function automatic t_dp_cmd step_cmd(input logic [STEP_W-1:0] step);
        t_dp_cmd c;
        case (step)
            STEP_W'(0):  c = mac_cmd(ACC_LOAD, A_MONO,  2'd0, B_MIX_M,  2'd0, W_NONE,   2'd0);
            STEP_W'(1):  c = mac_cmd(ACC_SUB,  A_DIFF,  2'd0, B_MIX_D,  2'd0, W_NONE,   2'd0);
            STEP_W'(2):  c = mac_cmd(ACC_LOAD, A_DET,   2'd0, B_KEEP,   2'd0, W_DRIVE1, 2'd1);
            STEP_W'(3):  c = mac_cmd(ACC_ADD,  A_DRIVE, 2'd0, B_TAKE,   2'd0, W_NONE,   2'd0);
            STEP_W'(4):  c = mac_cmd(ACC_LOAD, A_DET,   2'd1, B_KEEP,   2'd1, W_DET,    2'd0);
            STEP_W'(5):  c = mac_cmd(ACC_ADD,  A_DRIVE, 2'd1, B_TAKE,   2'd1, W_NONE,   2'd0);
            STEP_W'(6):  c = mac_cmd(ACC_LOAD, A_DET,   2'd2, B_KEEP,   2'd2, W_DET,    2'd1);
            STEP_W'(7):  c = mac_cmd(ACC_ADD,  A_DRIVE, 2'd2, B_TAKE,   2'd2, W_NONE,   2'd0);
            STEP_W'(8):  c = mac_cmd(ACC_LOAD, A_DET,   2'd3, B_KEEP,   2'd3, W_DET,    2'd2);
            STEP_W'(9):  c = mac_cmd(ACC_ADD,  A_DRIVE, 2'd3, B_TAKE,   2'd3, W_NONE,   2'd0);
            STEP_W'(10): c = mac_cmd(ACC_LOAD, A_ENV,   2'd0, B_DECAY,  2'd0, W_DET,    2'd3);
            STEP_W'(11): c = mac_cmd(ACC_LOAD, A_ENV,   2'd1, B_DECAY,  2'd1, W_ENV,    2'd0);
            STEP_W'(12): c = mac_cmd(ACC_LOAD, A_ENV,   2'd2, B_DECAY,  2'd2, W_ENV,    2'd1);
            STEP_W'(13): c = mac_cmd(ACC_LOAD, A_ENV,   2'd3, B_DECAY,  2'd3, W_ENV,    2'd2);
            STEP_W'(14): c = mac_cmd(ACC_LOAD, A_AMT,   2'd0, B_DUCK_K, 2'd0, W_ENV,    2'd3);
            STEP_W'(15): c = mac_cmd(ACC_LOAD, A_AMT,   2'd0, B_DUCK_K, 2'd1, W_AMTK,   2'd0);
            STEP_W'(16): c = mac_cmd(ACC_LOAD, A_AMT,   2'd0, B_DUCK_K, 2'd2, W_AMTK,   2'd1);
            STEP_W'(17): c = mac_cmd(ACC_LOAD, A_ENV,   2'd1, B_AMTK,   2'd0, W_AMTK,   2'd2);
            STEP_W'(18): c = mac_cmd(ACC_LOAD, A_ENV,   2'd2, B_AMTK,   2'd1, W_GAIN,   2'd0);
            STEP_W'(19): c = mac_cmd(ACC_LOAD, A_ENV,   2'd3, B_AMTK,   2'd2, W_GAIN,   2'd1);
            STEP_W'(20): c = mac_cmd(ACC_HOLD, A_MONO,  2'd0, B_MIX_M,  2'd0, W_GAIN,   2'd2);
            default:     c = idle_cmd();
        endcase
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = idle_cmd();
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd = step_cmd(r_step);
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/bedg_dp.sv
`timescale 1ns / 1ps

module bedg_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bedg_pkg::t_dp_cmd                  i_cmd,
    input  logic                               i_cfg_wr_en,
    input  logic        [bedg_pkg::AMT_W-1:0]  i_cfg_wr_data,
    input  logic signed [bedg_pkg::SMP_W-1:0]  i_left_sample,
    input  logic signed [bedg_pkg::SMP_W-1:0]  i_right_sample,
    output logic        [bedg_pkg::ENV_W-1:0]  o_low_envelope,
    output logic        [bedg_pkg::ENV_W-1:0]  o_low_mid_envelope,
    output logic        [bedg_pkg::ENV_W-1:0]  o_presence_envelope,
    output logic        [bedg_pkg::ENV_W-1:0]  o_air_envelope,
    output logic        [bedg_pkg::GAIN_W-1:0] o_low_mid_gain,
    output logic        [bedg_pkg::GAIN_W-1:0] o_presence_gain,
    output logic        [bedg_pkg::GAIN_W-1:0] o_air_gain
);
    import bedg_pkg::*;

    logic        [AMT_W-1:0]  r_amount;
    logic signed [SMP_W-1:0]  r_prev_mono;
    logic signed [SMP_W:0]    r_diff;
    logic        [ENV_W-1:0]  r_drive [4];
    logic        [ENV_W-1:0]  r_det [4];
    logic        [ENV_W-1:0]  r_env [4];
    logic        [AMTK_W-1:0] r_amtk [3];
    logic        [GAIN_W-1:0] r_gain [3];
    logic signed [PROD_W-1:0] r_acc;
    logic        [ENV_W-1:0]  r_out_env [4];
    logic        [GAIN_W-1:0] r_out_gain [3];

    logic signed [SMP_W:0]    sum;
    logic signed [SMP_W-1:0]  mono;
    logic signed [SMP_W:0]    diff;
    logic        [SMP_W-1:0]  mono_mag;
    logic        [SMP_W:0]    diff_mag;
    logic signed [ENV_W:0]    hp_ext;
    logic signed [ENV_W:0]    air_diff;
    logic        [ENV_W:0]    air_mag;
    logic        [ENV_W-1:0]  drive3;

    logic        [AMT_W-1:0]  amount;
    logic        [AMTK_W-1:0] amtk_sel;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;

    logic        [PROD_W-1:0] acc_mag;
    logic        [ENV_W-1:0]  mix_q;
    logic        [ENV_W-1:0]  det_q;
    logic        [ENV_W-1:0]  env_src;
    logic        [ENV_W-1:0]  env_q;
    logic        [PROD_W-DUCK_SHIFT-1:0] duck_raw;
    logic        [GAIN_W-1:0] duck_lim;
    logic        [GAIN_W-1:0] duck;

    // mono, difference and the drives that need no multiply
    assign sum      = {i_left_sample[SMP_W-1], i_left_sample}
                    + {i_right_sample[SMP_W-1], i_right_sample};
    assign mono     = sum[SMP_W:1];
    assign diff     = {mono[SMP_W-1], mono} - {r_prev_mono[SMP_W-1], r_prev_mono};
    assign mono_mag = mono[SMP_W-1] ? (~mono + 1'b1) : mono;
    assign diff_mag = diff[SMP_W] ? (~diff + 1'b1) : diff;
    assign hp_ext   = (ENV_W+1)'($signed({diff, {Q_SHIFT{1'b0}}}));
    assign air_diff = hp_ext - $signed({2'b00, r_det[3][ENV_W-1:1]});
    assign air_mag  = air_diff[ENV_W] ? (~air_diff + 1'b1) : air_diff;
    assign drive3   = air_mag[ENV_W] ? ENV_MAX : air_mag[ENV_W-1:0];

    assign amount = (r_amount > UNITY) ? UNITY : r_amount;

    always_comb begin
        case (i_cmd.b_idx)
            2'd0:    amtk_sel = r_amtk[0];
            2'd1:    amtk_sel = r_amtk[1];
            2'd2:    amtk_sel = r_amtk[2];
            default: amtk_sel = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.a_sel)
            A_MONO:  mul_a = MA_W'(r_prev_mono);
            A_DIFF:  mul_a = MA_W'(r_diff);
            A_DET:   mul_a = MA_W'(r_det[i_cmd.a_idx]);
            A_DRIVE: mul_a = MA_W'(r_drive[i_cmd.a_idx]);
            A_ENV:   mul_a = MA_W'(r_env[i_cmd.a_idx]);
            A_AMT:   mul_a = MA_W'(amount);
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.b_sel)
            B_MIX_M:  mul_b = MB_W'(MIX_M_COEF);
            B_MIX_D:  mul_b = MB_W'(MIX_D_COEF);
            B_KEEP:   mul_b = MB_W'(DET_KEEP[i_cmd.b_idx]);
            B_TAKE:   mul_b = MB_W'(DET_TAKE[i_cmd.b_idx]);
            B_DECAY:  mul_b = MB_W'(ENV_DECAY[i_cmd.b_idx]);
            B_DUCK_K: mul_b = MB_W'(duck_k(i_cmd.b_idx));
            B_AMTK:   mul_b = MB_W'(amtk_sel);
            default:  mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    // results of the finished accumulation
    assign acc_mag = r_acc[PROD_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign mix_q   = (|acc_mag[PROD_W-1:MIX_SHIFT+ENV_W]) ? ENV_MAX
                   : acc_mag[MIX_SHIFT+ENV_W-1:MIX_SHIFT];
    assign det_q   = (|r_acc[PROD_W-1:DET_SHIFT+ENV_W]) ? ENV_MAX
                   : r_acc[DET_SHIFT+ENV_W-1:DET_SHIFT];
    assign env_src = (i_cmd.wr_idx == 2'd0) ? r_drive[0] : r_det[i_cmd.wr_idx];
    assign env_q   = (env_src > det_q) ? env_src : det_q;

    assign duck_raw = r_acc[PROD_W-1:DUCK_SHIFT];
    assign duck_lim = duck_max(i_cmd.wr_idx);
    assign duck     = (duck_raw > (PROD_W-DUCK_SHIFT)'(duck_lim)) ? duck_lim
                    : duck_raw[GAIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount <= '0;
        end else if (i_cfg_wr_en) begin
            r_amount <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mono <= '0;
        end else if (i_cmd.load) begin
            r_prev_mono <= mono;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_diff     <= diff;
            r_drive[0] <= ENV_W'({mono_mag, {Q_SHIFT{1'b0}}});
            r_drive[2] <= ENV_W'({diff_mag, {Q_SHIFT{1'b0}}});
            r_drive[3] <= drive3;
        end
        if (i_cmd.wr_sel == W_DRIVE1) begin
            r_drive[1] <= mix_q;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= prod;
            ACC_ADD:  r_acc <= r_acc + prod;
            ACC_SUB:  r_acc <= r_acc - prod;
            default:  r_acc <= r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_det[i] <= '0;
                r_env[i] <= '0;
            end
        end else begin
            if (i_cmd.wr_sel == W_DET) begin
                r_det[i_cmd.wr_idx] <= det_q;
            end
            if (i_cmd.wr_sel == W_ENV) begin
                r_env[i_cmd.wr_idx] <= env_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sel == W_AMTK) begin
            case (i_cmd.wr_idx)
                2'd0:    r_amtk[0] <= r_acc[AMTK_W-1:0];
                2'd1:    r_amtk[1] <= r_acc[AMTK_W-1:0];
                2'd2:    r_amtk[2] <= r_acc[AMTK_W-1:0];
                default: r_amtk[0] <= r_amtk[0];
            endcase
        end
        if (i_cmd.wr_sel == W_GAIN) begin
            case (i_cmd.wr_idx)
                2'd0:    r_gain[0] <= UNITY - duck;
                2'd1:    r_gain[1] <= UNITY - duck;
                2'd2:    r_gain[2] <= UNITY - duck;
                default: r_gain[0] <= r_gain[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            for (int i = 0; i < 4; i++) begin
                r_out_env[i] <= r_env[i];
            end
            for (int j = 0; j < 3; j++) begin
                r_out_gain[j] <= r_gain[j];
            end
        end
    end

    assign o_low_envelope      = r_out_env[0];
    assign o_low_mid_envelope  = r_out_env[1];
    assign o_presence_envelope = r_out_env[2];
    assign o_air_envelope      = r_out_env[3];
    assign o_low_mid_gain      = r_out_gain[0];
    assign o_presence_gain     = r_out_gain[1];
    assign o_air_gain          = r_out_gain[2];

endmodule

### hw/rtl/band_envelope_dynamic_gain_top.sv
// Channel  Handshake                  Payload
// -------  -------------------------  ------------------------------------------
// input    i_in_valid / o_in_stall    i_left_sample, i_right_sample
// output   o_out_valid / i_out_stall  four envelopes, three duck gains
// config   i_cfg_wr_en                i_cfg_wr_data (dynamic amount)
//
// Each item is accepted, run through 21 steps of the shared multiply-accumulate
// unit and then loaded into the output register; o_in_stall stays high until then.
// Synchronous reset clears the detectors, envelopes, previous mono and amount.
// A result holds in the output register while i_out_stall is high; the next
// item is taken meanwhile and its result waits until the register frees.
`timescale 1ns / 1ps

module band_envelope_dynamic_gain_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [bedg_pkg::SMP_W-1:0]  i_left_sample,
    input  logic signed [bedg_pkg::SMP_W-1:0]  i_right_sample,
    input  logic                               i_cfg_wr_en,
    input  logic        [bedg_pkg::AMT_W-1:0]  i_cfg_wr_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic        [bedg_pkg::ENV_W-1:0]  o_low_envelope,
    output logic        [bedg_pkg::ENV_W-1:0]  o_low_mid_envelope,
    output logic        [bedg_pkg::ENV_W-1:0]  o_presence_envelope,
    output logic        [bedg_pkg::ENV_W-1:0]  o_air_envelope,
    output logic        [bedg_pkg::GAIN_W-1:0] o_low_mid_gain,
    output logic        [bedg_pkg::GAIN_W-1:0] o_presence_gain,
    output logic        [bedg_pkg::GAIN_W-1:0] o_air_gain
);
    import bedg_pkg::*;

    t_dp_cmd cmd;

    bedg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    bedg_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_left_sample       (i_left_sample),
        .i_right_sample      (i_right_sample),
        .o_low_envelope      (o_low_envelope),
        .o_low_mid_envelope  (o_low_mid_envelope),
        .o_presence_envelope (o_presence_envelope),
        .o_air_envelope      (o_air_envelope),
        .o_low_mid_gain      (o_low_mid_gain),
        .o_presence_gain     (o_presence_gain),
        .o_air_gain          (o_air_gain)
    );

endmodule
